>>> hdl/homeostatic_bias_adaptation_unit_assert.svh
// Assertion macros used by the port checker of this block.
`ifndef HOMEOSTATIC_BIAS_ADAPTATION_UNIT_ASSERT_SVH
`define HOMEOSTATIC_BIAS_ADAPTATION_UNIT_ASSERT_SVH

// Check next cycle, quiet while reset is high.
`define HBA_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

// Check next cycle, also across reset.
`define HBA_ASSERT_NEXT_ALWAYS(label, cond, cons, msg) \
   label: assert property (@(posedge clock) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hba_pkg.sv
`default_nettype none

package hba_pkg;

   localparam int DATA_W      = 32;
   localparam int WIDE_W      = 64;
   localparam int CNT_W       = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 72;

   // 1.0 in Q16.16, subtracted on an own spike
   localparam logic [WIDE_W-1:0] ONE_Q16   = 64'd65536;
   // largest bias step magnitude, 2^33
   localparam logic [33:0]       STEP_CAP  = 34'h2_0000_0000;
   localparam logic [DATA_W-1:0] Q_MAX     = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
   localparam logic [CNT_W-1:0]  CNT_LAST  = 5'd31;

   typedef enum logic [2:0] {
      CMD_SPIKE      = 3'd0,
      CMD_RATE_EVENT = 3'd1,
      CMD_TOGGLE     = 3'd2,
      CMD_TICK       = 3'd3,
      CMD_SET_ACTIVE = 3'd4,
      CMD_RESET      = 3'd5
   } hba_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BIAS_RATE    = 3'd0,
      REG_TARGET_GAIN  = 3'd1,
      REG_RATE_SCALE   = 3'd2,
      REG_THRESHOLD    = 3'd3,
      REG_BIAS_FLOOR   = 3'd4,
      REG_BIAS_CEILING = 3'd5,
      REG_BIAS_INITIAL = 3'd6
   } hba_reg_type;

   typedef struct packed {
      logic [DATA_W-1:0] bias_rate;
      logic [DATA_W-1:0] target_rate_gain;
      logic [DATA_W-1:0] rate_scale;
      logic [DATA_W-1:0] potential_threshold;
      logic [DATA_W-1:0] bias_floor;
      logic [DATA_W-1:0] bias_ceiling;
      logic [DATA_W-1:0] bias_initial;
   } hba_cfg_type;

   localparam hba_cfg_type CFG_RESET = '{
      bias_rate:           32'd0,
      target_rate_gain:    32'd0,
      rate_scale:          32'd65536,
      potential_threshold: 32'd0,
      bias_floor:          32'h8000_0000,
      bias_ceiling:        32'h7fff_ffff,
      bias_initial:        32'd0
   };

   typedef struct packed {
      logic busy;
      logic neg;
   } hba_unit_status_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_MUL1,
      UNIT_MAG,
      UNIT_MUL2
   } hba_unit_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_UPDATE,
      ST_OUTPUT
   } hba_state_type;

endpackage

`default_nettype wire

>>> hdl/hba_csr_regs.sv
`default_nettype none

module hba_csr_regs
   import hba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output hba_cfg_type          cfg
);

   hba_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (hba_reg_type'(csr_index))
            REG_BIAS_RATE:    cfg_in.bias_rate           = csr_wdata;
            REG_TARGET_GAIN:  cfg_in.target_rate_gain    = csr_wdata;
            REG_RATE_SCALE:   cfg_in.rate_scale          = csr_wdata;
            REG_THRESHOLD:    cfg_in.potential_threshold = csr_wdata;
            REG_BIAS_FLOOR:   cfg_in.bias_floor          = csr_wdata;
            REG_BIAS_CEILING: cfg_in.bias_ceiling        = csr_wdata;
            REG_BIAS_INITIAL: cfg_in.bias_initial        = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/hba_scaler.sv
`default_nettype none

// Serial shift-add unit: magnitude of (operand * elapsed - offset), then
// that magnitude times an unsigned Q0.32 gain, truncated. One multiplier
// bit per cycle in each pass.
module hba_scaler
   import hba_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DATA_W:0]  operand,
   input  logic [DATA_W-1:0]       elapsed,
   input  logic                    offset_en,
   input  logic [DATA_W-1:0]       gain,
   output hba_unit_status_type     status,
   output logic [WIDE_W-1:0]       magnitude
);

   hba_unit_state_type state_ff, state_in;
   logic [WIDE_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  low_ff, low_in;
   logic [WIDE_W-1:0]  mcand_ff, mcand_in;
   logic [DATA_W-1:0]  mult_ff, mult_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               sign_ff, sign_in;
   logic               off_ff, off_in;
   logic               neg_ff, neg_in;

   logic [WIDE_W:0]    sum;
   logic [WIDE_W-1:0]  prod;
   logic [WIDE_W:0]    diff;
   logic [DATA_W:0]    op_mag;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         UNIT_IDLE: if (start) state_in = UNIT_MUL1;
         UNIT_MUL1: if (cnt_ff == CNT_LAST) state_in = UNIT_MAG;
         UNIT_MAG:  state_in = UNIT_MUL2;
         UNIT_MUL2: if (cnt_ff == CNT_LAST) state_in = UNIT_IDLE;
         default:   state_in = UNIT_IDLE;
      endcase
   end

   always_comb begin
      sum    = {1'b0, acc_ff} + (mult_ff[0] ? {1'b0, mcand_ff} : {(WIDE_W+1){1'b0}});
      prod   = {acc_ff[DATA_W-1:0], low_ff};
      diff   = {1'b0, prod} - {1'b0, ONE_Q16};
      op_mag = operand[DATA_W] ? (~$unsigned(operand) + 33'd1) : $unsigned(operand);

      acc_in   = acc_ff;
      low_in   = low_ff;
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      off_in   = off_ff;
      neg_in   = neg_ff;

      unique case (state_ff)
         UNIT_IDLE: begin
            if (start) begin
               acc_in   = '0;
               low_in   = '0;
               mcand_in = {{(WIDE_W-DATA_W-1){1'b0}}, op_mag};
               mult_in  = elapsed;
               cnt_in   = '0;
               sign_in  = operand[DATA_W];
               off_in   = offset_en;
            end
         end
         UNIT_MUL1, UNIT_MUL2: begin
            // add, then shift the partial product right one place
            acc_in  = sum[WIDE_W:1];
            low_in  = {sum[0], low_ff[DATA_W-1:1]};
            mult_in = {1'b0, mult_ff[DATA_W-1:1]};
            cnt_in  = cnt_ff + 5'd1;
         end
         UNIT_MAG: begin
            acc_in  = '0;
            low_in  = '0;
            mult_in = gain;
            cnt_in  = '0;
            if (!off_ff) begin
               mcand_in = prod;
               neg_in   = sign_ff;
            end else if (sign_ff) begin
               mcand_in = prod + ONE_Q16;
               neg_in   = 1'b1;
            end else if (diff[WIDE_W]) begin
               mcand_in = ONE_Q16 - prod;
               neg_in   = 1'b1;
            end else begin
               mcand_in = diff[WIDE_W-1:0];
               neg_in   = 1'b0;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      low_ff   <= low_in;
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
      sign_ff  <= sign_in;
      off_ff   <= off_in;
      neg_ff   <= neg_in;
   end

   assign status.busy = (state_ff != UNIT_IDLE);
   assign status.neg  = neg_ff;
   assign magnitude   = acc_ff;

endmodule

`default_nettype wire

>>> hdl/homeostatic_bias_adaptation_unit.sv
// Homeostatic bias adaptation, one neuron, signed Q16.16 with Q0.32 rates.
// Each accepted item (command in req_tuser) yields exactly one result with
// the bias, target rate and active mode after that item. Spike, rate event
// and rate update tick while active run two serial scaler units side by
// side, each doing two 32-step shift-add passes (time times rate, then
// times the learning rate), then the update and output steps. All other
// commands, and those three while inactive, go straight to the update
// step. A stalled result sits in the output register; the next item is
// accepted meanwhile and waits in its output step until the register is
// free. Configuration registers are written by index through csr_wr_en
// and are registered before they take effect; write them only while
// no item is in flight.
`default_nettype none

module homeostatic_bias_adaptation_unit
   import hba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // timestamp[31:0], membrane_potential[63:32], active_flag[64], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // bias_out[31:0], target_rate_out[63:32], active_out[64], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   hba_cfg_type         cfg;
   hba_unit_status_type bias_st, target_st;
   logic [WIDE_W-1:0]   bias_mag, target_mag;

   hba_state_type     state_ff, state_in;
   hba_cmd_type       cmd_ff, cmd_in;
   logic [DATA_W-1:0] ts_ff, ts_in;
   logic [DATA_W-1:0] vm_ff, vm_in;
   logic              flag_ff, flag_in;

   logic [DATA_W-1:0] bias_ff, bias_in;
   logic [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0] last_bias_ff, last_bias_in;
   logic [DATA_W-1:0] last_rate_ff, last_rate_in;
   logic              prev_above_ff, prev_above_in;
   logic              active_ff, active_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   hba_cmd_type       req_cmd;
   logic [DATA_W-1:0] req_ts;
   logic              accept, needs_unit, start, rsp_load;
   logic [DATA_W:0]   bias_operand, target_operand, drive;
   logic [DATA_W-1:0] bias_elapsed, target_elapsed;

   logic [33:0]       step_cap;
   logic [35:0]       step_b, nb, floor_x, ceil_x;
   logic [DATA_W-1:0] bias_new;
   logic [WIDE_W-1:0] step_t, t_sum;
   logic [DATA_W-1:0] target_new;
   logic              above;

   hba_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_cmd    = hba_cmd_type'(req_tuser);
   assign req_ts     = req_tdata[DATA_W-1:0];
   assign accept     = req_tvalid && req_tready;
   assign needs_unit = active_ff && (req_cmd inside {CMD_SPIKE, CMD_RATE_EVENT, CMD_TICK});
   assign start      = accept && needs_unit;

   assign bias_operand   = {target_ff[DATA_W-1], target_ff};
   assign bias_elapsed   = req_ts - last_bias_ff;
   assign drive          = prev_above_ff ? {cfg.rate_scale[DATA_W-1], cfg.rate_scale}
                                         : {(DATA_W+1){1'b0}};
   assign target_operand = drive - {target_ff[DATA_W-1], target_ff};
   assign target_elapsed = req_ts - last_rate_ff;

   hba_scaler u_bias_scaler (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operand   ($signed(bias_operand)),
      .elapsed   (bias_elapsed),
      .offset_en (req_cmd == CMD_SPIKE),
      .gain      (cfg.bias_rate),
      .status    (bias_st),
      .magnitude (bias_mag)
   );

   hba_scaler u_target_scaler (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operand   ($signed(target_operand)),
      .elapsed   (target_elapsed),
      .offset_en (1'b0),
      .gain      (cfg.target_rate_gain),
      .status    (target_st),
      .magnitude (target_mag)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = needs_unit ? ST_RUN : ST_UPDATE;
         ST_RUN:    if (!bias_st.busy && !target_st.busy) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUTPUT;
         ST_OUTPUT: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_OUTPUT: rsp_load   = !rsp_valid_ff || rsp_tready;
         default:   req_tready = 1'b0;
      endcase
   end

   // clamp the bias step, add, clamp to floor then ceiling
   always_comb begin
      step_cap = (bias_mag > {{(WIDE_W-34){1'b0}}, STEP_CAP}) ? STEP_CAP : bias_mag[33:0];
      step_b   = bias_st.neg ? (~{2'b00, step_cap} + 36'd1) : {2'b00, step_cap};
      nb       = {{4{bias_ff[DATA_W-1]}}, bias_ff} + step_b;
      floor_x  = {{4{cfg.bias_floor[DATA_W-1]}}, cfg.bias_floor};
      ceil_x   = {{4{cfg.bias_ceiling[DATA_W-1]}}, cfg.bias_ceiling};
      if ($signed(nb) <= $signed(floor_x)) begin
         bias_new = cfg.bias_floor;
      end else if ($signed(nb) >= $signed(ceil_x)) begin
         bias_new = cfg.bias_ceiling;
      end else begin
         bias_new = nb[DATA_W-1:0];
      end

      // wide sum wraps at 64 bits before saturating
      step_t = target_st.neg ? (~target_mag + 64'd1) : target_mag;
      t_sum  = {{(WIDE_W-DATA_W){target_ff[DATA_W-1]}}, target_ff} + step_t;
      if ((t_sum[WIDE_W-1:DATA_W-1] == '0) || (t_sum[WIDE_W-1:DATA_W-1] == '1)) begin
         target_new = t_sum[DATA_W-1:0];
      end else begin
         target_new = t_sum[WIDE_W-1] ? Q_MIN : Q_MAX;
      end

      above = $signed(vm_ff) > $signed(cfg.potential_threshold);
   end

   // item capture and state update
   always_comb begin
      cmd_in        = cmd_ff;
      ts_in         = ts_ff;
      vm_in         = vm_ff;
      flag_in       = flag_ff;
      bias_in       = bias_ff;
      target_in     = target_ff;
      last_bias_in  = last_bias_ff;
      last_rate_in  = last_rate_ff;
      prev_above_in = prev_above_ff;
      active_in     = active_ff;

      if (accept) begin
         cmd_in  = req_cmd;
         ts_in   = req_ts;
         vm_in   = req_tdata[2*DATA_W-1:DATA_W];
         flag_in = req_tdata[2*DATA_W];
      end

      if (state_ff == ST_UPDATE) begin
         unique case (cmd_ff)
            CMD_SPIKE: begin
               if (active_ff) begin
                  bias_in      = bias_new;
                  last_bias_in = ts_ff;
               end
            end
            CMD_RATE_EVENT, CMD_TICK: begin
               if (active_ff) begin
                  if (cmd_ff == CMD_RATE_EVENT) begin
                     bias_in      = bias_new;
                     last_bias_in = ts_ff;
                  end
                  target_in     = target_new;
                  last_rate_in  = ts_ff;
                  prev_above_in = above;
               end
            end
            CMD_TOGGLE: begin
               active_in = !active_ff;
               if (!active_ff) begin
                  last_bias_in  = ts_ff;
                  last_rate_in  = ts_ff;
                  prev_above_in = above;
               end
            end
            CMD_SET_ACTIVE: begin
               active_in = flag_ff;
               if (flag_ff) begin
                  last_bias_in  = ts_ff;
                  last_rate_in  = ts_ff;
                  prev_above_in = above;
               end
            end
            CMD_RESET: begin
               bias_in       = cfg.bias_initial;
               target_in     = '0;
               last_bias_in  = '0;
               last_rate_in  = '0;
               prev_above_in = above;
            end
            default: begin
               // unused codes change nothing
               bias_in = bias_ff;
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_TDATA_W-2*DATA_W-1){1'b0}}, active_ff, target_ff, bias_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         bias_ff       <= CFG_RESET.bias_initial;
         target_ff     <= '0;
         last_bias_ff  <= '0;
         last_rate_ff  <= '0;
         prev_above_ff <= 1'b0;
         active_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         bias_ff       <= bias_in;
         target_ff     <= target_in;
         last_bias_ff  <= last_bias_in;
         last_rate_ff  <= last_rate_in;
         prev_above_ff <= prev_above_in;
         active_ff     <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ts_ff       <= ts_in;
      vm_ff       <= vm_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/hba_port_checker.sv
`default_nettype none
`include "homeostatic_bias_adaptation_unit_assert.svh"

module hba_port_checker
   import hba_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   `HBA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // one item at a time: ready drops right after an accept
   `HBA_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second item taken while busy")

   // a result never appears in the cycle right after its item
   `HBA_ASSERT_NEXT(a_no_early_result, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")

   // reset drops any pending result
   `HBA_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind homeostatic_bias_adaptation_unit hba_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/tb_homeostatic_bias_adaptation_unit.sv
module tb_homeostatic_bias_adaptation_unit;
   import hba_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLDOFF_LEN  = 300;
   localparam int HOLDOFF_AT   = 120;
   localparam int CALM_FIRST   = 250;
   localparam int CALM_LAST    = 330;
   localparam int RANDOM_ITEMS = 88;
   localparam int NUM_PHASES   = 7;

   typedef struct packed {
      hba_cmd_type cmd;
      logic [31:0] ts;
      logic [31:0] vm;
      logic        flag;
   } neuron_event_type;

   typedef struct packed {
      logic        active;
      logic [31:0] target;
      logic [31:0] bias;
   } neuron_outputs_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]      csr_wdata = '0;

   homeostatic_bias_adaptation_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow of the neuron state and the register file
   hba_cfg_type        shadow_cfg = CFG_RESET;
   logic signed [31:0] nrn_bias = '0;
   logic signed [31:0] nrn_target = '0;
   logic [31:0]        nrn_bias_ts = '0;
   logic [31:0]        nrn_rate_ts = '0;
   logic               nrn_above = 1'b0;
   logic               nrn_active = 1'b0;

   neuron_event_type   pending_events[$];
   neuron_outputs_type awaited_outputs[$];
   neuron_event_type   offered_event;
   neuron_outputs_type want;

   int   items_sent = 0;
   int   results_seen = 0;
   int   mismatches = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   logic hold_fired = 1'b0;

   function automatic longint sext(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // floor(mag * g / 2^32), exact
   function automatic logic [63:0] q032_scale(logic [63:0] mag, logic [31:0] g);
      logic [95:0] p;
      p = {32'd0, mag} * {64'd0, g};
      return p[95:32];
   endfunction

   function automatic logic above_threshold(logic [31:0] vm);
      return $signed(vm) > $signed(shadow_cfg.potential_threshold);
   endfunction

   task automatic adjust_bias(input longint x, input logic [31:0] ts);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] r;
      longint      nb;
      neg = x < 0;
      mag = neg ? -x : x;
      r = q032_scale(mag, shadow_cfg.bias_rate);
      if (r > {30'd0, STEP_CAP})
         r = {30'd0, STEP_CAP};
      nb = sext(nrn_bias) + (neg ? -longint'(r) : longint'(r));
      // floor wins when the limits cross
      if (nb <= sext(shadow_cfg.bias_floor))
         nb = sext(shadow_cfg.bias_floor);
      else if (nb >= sext(shadow_cfg.bias_ceiling))
         nb = sext(shadow_cfg.bias_ceiling);
      nrn_bias = nb[31:0];
      nrn_bias_ts = ts;
   endtask

   task automatic track_target(input logic [31:0] ts, input logic [31:0] vm);
      logic [31:0] dt;
      longint      d;
      longint      t;
      logic        neg;
      logic [63:0] mag;
      logic [63:0] r;
      if (nrn_active) begin
         dt = ts - nrn_rate_ts;
         d = (nrn_above ? sext(shadow_cfg.rate_scale) : longint'(0)) - sext(nrn_target);
         neg = d < 0;
         mag = neg ? -d : d;
         r = q032_scale(mag * {32'd0, dt}, shadow_cfg.target_rate_gain);
         // the sum wraps at 64 bits before saturation
         t = sext(nrn_target) + (neg ? -longint'(r) : longint'(r));
         if (t > sext(Q_MAX))
            t = sext(Q_MAX);
         if (t < sext(Q_MIN))
            t = sext(Q_MIN);
         nrn_target = t[31:0];
         nrn_rate_ts = ts;
         nrn_above = above_threshold(vm);
      end
   endtask

   task automatic wake_neuron(input neuron_event_type ev);
      nrn_bias_ts = ev.ts;
      nrn_rate_ts = ev.ts;
      nrn_above = above_threshold(ev.vm);
   endtask

   task automatic apply_neuron_event(input neuron_event_type ev);
      logic [31:0]        dt;
      neuron_outputs_type o;
      dt = ev.ts - nrn_bias_ts;
      case (ev.cmd)
         CMD_SPIKE: begin
            if (nrn_active)
               adjust_bias(sext(nrn_target) * longint'({32'd0, dt}) - longint'(ONE_Q16),
                           ev.ts);
         end
         CMD_RATE_EVENT: begin
            if (nrn_active)
               adjust_bias(sext(nrn_target) * longint'({32'd0, dt}), ev.ts);
            track_target(ev.ts, ev.vm);
         end
         CMD_TOGGLE: begin
            nrn_active = !nrn_active;
            if (nrn_active)
               wake_neuron(ev);
         end
         CMD_TICK: begin
            track_target(ev.ts, ev.vm);
         end
         CMD_SET_ACTIVE: begin
            nrn_active = ev.flag;
            if (nrn_active)
               wake_neuron(ev);
         end
         CMD_RESET: begin
            nrn_bias = shadow_cfg.bias_initial;
            nrn_target = '0;
            nrn_bias_ts = '0;
            nrn_rate_ts = '0;
            nrn_above = above_threshold(ev.vm);
         end
         default: ;
      endcase
      o.bias = nrn_bias;
      o.target = nrn_target;
      o.active = nrn_active;
      awaited_outputs.push_back(o);
   endtask

   task automatic post_event(input hba_cmd_type cmd, input logic [31:0] ts,
                             input logic [31:0] vm, input logic flag);
      neuron_event_type ev;
      ev.cmd = cmd;
      ev.ts = ts;
      ev.vm = vm;
      ev.flag = flag;
      pending_events.push_back(ev);
   endtask

   task automatic write_csr(input hba_reg_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_BIAS_RATE:    shadow_cfg.bias_rate = val;
         REG_TARGET_GAIN:  shadow_cfg.target_rate_gain = val;
         REG_RATE_SCALE:   shadow_cfg.rate_scale = val;
         REG_THRESHOLD:    shadow_cfg.potential_threshold = val;
         REG_BIAS_FLOOR:   shadow_cfg.bias_floor = val;
         REG_BIAS_CEILING: shadow_cfg.bias_ceiling = val;
         REG_BIAS_INITIAL: shadow_cfg.bias_initial = val;
         default: ;
      endcase
   endtask

   task automatic wait_until_drained();
      while (pending_events.size() != 0 || req_tvalid || awaited_outputs.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_neuron_event(offered_event);
            items_sent++;
         end
         if (pending_events.size() != 0 &&
             ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
              $urandom_range(0, 99) >= 25)) begin
            offered_event = pending_events.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, offered_event.flag, offered_event.vm, offered_event.ts};
            req_tuser <= offered_event.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the input side backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_fired && results_seen >= HOLDOFF_AT) begin
         hold_left <= HOLDOFF_LEN;
         hold_fired <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (awaited_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing expected: %h",
                           results_seen, rsp_tdata);
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_tdata[31:0] !== want.bias || rsp_tdata[63:32] !== want.target ||
                   rsp_tdata[64] !== want.active) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: bias %h/%h target %h/%h active %b/%b (exp/got)",
                              results_seen, want.bias, rsp_tdata[31:0], want.target,
                              rsp_tdata[63:32], want.active, rsp_tdata[64]);
               end
            end
         end
         if (hold_left != 0)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                          $urandom_range(0, 99) >= 25;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("homeostatic_bias_adaptation_unit verification failed");
         $finish;
      end
   end

   initial begin
      int            p;
      int            i;
      int            roll;
      int            pick;
      logic [31:0]   now;
      logic [31:0]   vm;
      hba_cmd_type   cmd;
      hba_cfg_type   next_cfg;
      now = 32'd1000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (p = 1; p <= NUM_PHASES; p++) begin
         wait_until_drained();
         case (p)
            1: next_cfg = '{32'h0100_0000, 32'h0400_0000, 32'h0001_0000, 32'h0000_0000,
                            32'hFFF6_0000, 32'h000A_0000, 32'h0000_8000};
            2: next_cfg = '{32'h0040_0000, 32'h0010_0000, 32'h0002_0000, 32'h0000_0000,
                            32'hFF9C_0000, 32'h0064_0000, 32'hFFFF_0000};
            3: next_cfg = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            // floor above ceiling
            4: next_cfg = '{32'h1000_0000, 32'h0100_0000, 32'hFFFD_0000, 32'h7FFF_FFFF,
                            32'h0005_0000, 32'hFFFB_0000, 32'h8000_0000};
            5: next_cfg = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                            32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000};
            6: next_cfg = '{$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom};
            default: next_cfg = '{32'h4000_0000, 32'h1000_0000, 32'h0001_0000, $urandom,
                                  32'hFFFF_8000, 32'h0000_8000, 32'h0000_4000};
         endcase
         write_csr(REG_BIAS_RATE, next_cfg.bias_rate);
         write_csr(REG_TARGET_GAIN, next_cfg.target_rate_gain);
         write_csr(REG_RATE_SCALE, next_cfg.rate_scale);
         write_csr(REG_THRESHOLD, next_cfg.potential_threshold);
         write_csr(REG_BIAS_FLOOR, next_cfg.bias_floor);
         write_csr(REG_BIAS_CEILING, next_cfg.bias_ceiling);
         write_csr(REG_BIAS_INITIAL, next_cfg.bias_initial);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         if (p == 1) begin
            // inactive commands first, then clamps, wraps and activation paths
            post_event(CMD_SPIKE,      32'd5,          32'h0000_0000, 1'b0);
            post_event(CMD_RATE_EVENT, 32'd6,          32'h0001_0000, 1'b1);
            post_event(CMD_TICK,       32'd7,          32'h0001_0000, 1'b0);
            post_event(CMD_TOGGLE,     32'd10,         32'h0001_0000, 1'b0);
            post_event(CMD_TICK,       32'd40,         32'hFFFF_0000, 1'b0);
            post_event(CMD_RATE_EVENT, 32'd100,        32'h7FFF_FFFF, 1'b1);
            post_event(CMD_SPIKE,      32'd200,        32'h0000_0000, 1'b0);
            post_event(CMD_SPIKE,      32'd200,        32'h0000_0000, 1'b0);
            post_event(CMD_SET_ACTIVE, 32'd300,        32'h8000_0000, 1'b1);
            post_event(CMD_TICK,       32'hFFFF_FFFF,  32'h8000_0000, 1'b0);
            post_event(CMD_SPIKE,      32'h0000_0010,  32'h0000_0000, 1'b0);
            post_event(CMD_SET_ACTIVE, 32'd20,         32'h0001_0000, 1'b1);
            post_event(CMD_TICK,       32'h8000_0000,  32'h0000_0000, 1'b0);
            post_event(CMD_RATE_EVENT, 32'hFFFF_FFFF,  32'h0001_0000, 1'b1);
            post_event(CMD_SET_ACTIVE, 32'hFFFF_FFFF,  32'h0000_0000, 1'b0);
            post_event(CMD_SPIKE,      32'd0,          32'h0000_0000, 1'b0);
            post_event(CMD_TICK,       32'd1,          32'h7FFF_FFFF, 1'b1);
            post_event(CMD_RESET,      32'd0,          32'h7FFF_FFFF, 1'b1);
            post_event(CMD_TOGGLE,     32'd50,         32'h8000_0000, 1'b1);
            post_event(CMD_TOGGLE,     32'd60,         32'h0000_0000, 1'b0);
            post_event(CMD_SET_ACTIVE, 32'd0,          32'h0000_0000, 1'b1);
            post_event(CMD_RATE_EVENT, 32'd0,          32'h0000_0000, 1'b0);
            post_event(CMD_RESET,      32'd100,        32'h0000_0000, 1'b0);
            post_event(CMD_SPIKE,      32'hFFFF_FFFF,  32'h0000_0000, 1'b0);
         end else begin
            post_event(CMD_SET_ACTIVE, now, $urandom, 1'b1);
            for (i = 0; i < RANDOM_ITEMS; i++) begin
               roll = $urandom_range(0, 99);
               if (roll < 85) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 35)
                     cmd = CMD_SPIKE;
                  else if (pick < 65)
                     cmd = CMD_RATE_EVENT;
                  else if (pick < 85)
                     cmd = CMD_TICK;
                  else if (pick < 88)
                     cmd = CMD_TOGGLE;
                  else if (pick < 95)
                     cmd = CMD_SET_ACTIVE;
                  else
                     cmd = CMD_RESET;
                  if ($urandom_range(0, 9) == 0)
                     now = now + $urandom_range(0, 1 << 20);
                  else
                     now = now + $urandom_range(0, 3000);
                  // keep the potential near the threshold half the time
                  if ($urandom_range(0, 1) == 1)
                     vm = shadow_cfg.potential_threshold + $urandom_range(0, 131072) - 65536;
                  else
                     vm = $urandom;
                  post_event(cmd, now, vm, $urandom_range(0, 5) != 0);
               end else begin
                  post_event(hba_cmd_type'($urandom_range(0, 5)), $urandom, $urandom,
                             $urandom_range(0, 1) == 1);
               end
            end
         end
      end
      wait_until_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && awaited_outputs.size() == 0)
         $display("homeostatic_bias_adaptation_unit verification clean");
      else
         $display("homeostatic_bias_adaptation_unit verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hba_pkg.sv
hdl/hba_csr_regs.sv
hdl/hba_scaler.sv
hdl/homeostatic_bias_adaptation_unit.sv
hdl/hba_port_checker.sv
tb/tb_homeostatic_bias_adaptation_unit.sv
